[hdl/button_press_classifier_assert.svh]
// Assertion macros shared by the button press classifier modules.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on clk, disabled while rst_n is low.
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk, also during reset.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPC_ASSERT(label, prop, msg)
`define BPC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hdl/bpc_pkg.sv]
// Types and constants shared by the button press classifier modules.
package bpc_pkg;

  // Width of the threshold registers.
  localparam int CFG_W = 24;

  // Register indexes on the configuration port.
  localparam logic CFG_IDX_LONG   = 1'b0;
  localparam logic CFG_IDX_WINDOW = 1'b1;

  // Reset values of the thresholds.
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET    = 24'd1200000;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET = 24'd400000;

  // Gesture codes.
  localparam logic [1:0] G_NONE   = 2'd0;
  localparam logic [1:0] G_SINGLE = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_LONG   = 2'd3;

  // Threshold settings handed from the register block to the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] double_window_ticks;
  } bpc_cfg_t;

endpackage

[hdl/bpc_regs.sv]
// Configuration registers of the button press classifier with an APB-style port.
module bpc_regs
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output bpc_cfg_t    cfg_o
);

  logic [CFG_W-1:0] long_r;
  logic [CFG_W-1:0] window_r;
  logic             wr_en;
  logic             idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[2];

  // Write the addressed threshold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r   <= LONG_PRESS_RESET;
      window_r <= DOUBLE_WINDOW_RESET;
    end else if (wr_en) begin
      unique case (idx)
        CFG_IDX_LONG:   long_r   <= cfg_pwdata[CFG_W-1:0];
        CFG_IDX_WINDOW: window_r <= cfg_pwdata[CFG_W-1:0];
        default:        ;
      endcase
    end
  end

  // Return the addressed threshold on reads.
  always_comb begin
    unique case (idx)
      CFG_IDX_LONG:   cfg_prdata = {{(32-CFG_W){1'b0}}, long_r};
      CFG_IDX_WINDOW: cfg_prdata = {{(32-CFG_W){1'b0}}, window_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg_o.long_press_ticks    = long_r;
  assign cfg_o.double_window_ticks = window_r;

endmodule

[hdl/bpc_core.sv]
// Gesture classification: press state, hold and since-release counters.
module bpc_core
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bpc_cfg_t   cfg_i,
  input  logic       acc_i,
  input  logic       pressed_i,
  output logic [1:0] gesture_o
);

  `include "button_press_classifier_assert.svh"

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  prev_r, prev_nxt;
  logic                  pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] hold_r, hold_nxt;
  logic [COUNT_BITS-1:0] since_r, since_nxt;
  logic [COUNT_BITS-1:0] hold_inc, since_inc;
  logic [CMP_W-1:0]      hold_x, since_x, long_x, window_x;
  logic                  press_edge, release_edge;

  // Advance the counters, saturating at all ones.
  assign since_inc = (&since_r) ? since_r : since_r + 1'b1;
  assign hold_inc  = (prev_r && !(&hold_r)) ? hold_r + 1'b1 : hold_r;

  assign hold_x   = CMP_W'(hold_inc);
  assign since_x  = CMP_W'(since_inc);
  assign long_x   = CMP_W'(cfg_i.long_press_ticks);
  assign window_x = CMP_W'(cfg_i.double_window_ticks);

  assign press_edge   = pressed_i && !prev_r;
  assign release_edge = !pressed_i && prev_r;

  // Decide the gesture and the next state for this tick.
  always_comb begin
    prev_nxt  = pressed_i;
    pend_nxt  = pend_r;
    hold_nxt  = hold_inc;
    since_nxt = since_inc;
    gesture_o = G_NONE;
    if (press_edge) begin
      hold_nxt = '0;
    end else if (release_edge) begin
      if (hold_x > long_x) begin
        pend_nxt  = 1'b0;
        gesture_o = G_LONG;
      end else if (pend_r && (since_x < window_x)) begin
        pend_nxt  = 1'b0;
        gesture_o = G_DOUBLE;
      end else begin
        pend_nxt  = 1'b1;
        since_nxt = '0;
      end
    end else if (pend_r && !pressed_i && (since_x > window_x)) begin
      pend_nxt  = 1'b0;
      gesture_o = G_SINGLE;
    end
  end

  // Update the state on each accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      pend_r  <= 1'b0;
      hold_r  <= '0;
      since_r <= '0;
    end else if (acc_i) begin
      prev_r  <= prev_nxt;
      pend_r  <= pend_nxt;
      hold_r  <= hold_nxt;
      since_r <= since_nxt;
    end
  end

  `BPC_ASSERT(a_press_clears_hold, (acc_i && press_edge) |=> (prev_r && hold_r == '0), "press edge must clear hold")
  `BPC_ASSERT(a_gesture_clears_pend, (acc_i && gesture_o != G_NONE) |=> !pend_r, "reported gesture must clear pending single")
  `BPC_ASSERT(a_release_idle, (acc_i && release_edge) |=> !prev_r, "release must leave button up")

endmodule

[hdl/bpc_skid.sv]
// Two-entry output stage that holds results while the downstream side stalls.
module bpc_skid
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  logic [1:0] gesture_i,
  output logic       ready_o,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] gesture_o
);

  `include "button_press_classifier_assert.svh"

  logic       out_valid_r;
  logic [1:0] out_data_r;
  logic       skid_valid_r;
  logic [1:0] skid_data_r;
  logic       drain;

  assign ready_o    = !skid_valid_r;
  assign drain      = out_tready || !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign gesture_o  = out_data_r;

  // Move the skid entry forward, or park a request while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push_i;
      end
    end else if (push_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves with the valid bits.
  always_ff @(posedge clk) begin
    if (drain) begin
      out_data_r <= skid_valid_r ? skid_data_r : gesture_i;
    end else if (push_i) begin
      skid_data_r <= gesture_i;
    end
  end

  `BPC_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid entry without output entry")
  `BPC_ASSERT(a_stall_parks, (out_valid_r && !out_tready && push_i) |=> skid_valid_r, "stalled request lost")
  `BPC_ASSERT(a_skid_refills, (skid_valid_r && out_tready) |=> (out_valid_r && !skid_valid_r), "skid entry not moved out")

endmodule

[hdl/button_press_classifier.sv]
// Top level of the button press classifier.
// Takes one sampled button level per clock while in_tready is high and returns one
// gesture code per level (0 none, 1 single, 2 double, 3 long press). The classifier
// updates its counters and decides the gesture in the cycle the request is accepted,
// and the result is registered in the output stage. A two-entry output stage
// lets one more request be accepted after the output stalls. The user must write
// thresholds through the configuration port while idle; the block does not enforce this.
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] pressed, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] gesture, [7:2] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bpc_cfg_t   cfg;
  logic       acc;
  logic [1:0] gesture;
  logic [1:0] out_gesture;

  assign acc       = in_tvalid && in_tready;
  assign out_tdata = {6'b0, out_gesture};

  bpc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  bpc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .acc_i     (acc),
    .pressed_i (in_tdata[0]),
    .gesture_o (gesture)
  );

  bpc_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (acc),
    .gesture_i  (gesture),
    .ready_o    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .gesture_o  (out_gesture)
  );

endmodule
